// ===== hw/rtl/rslg_pkg.sv =====
// ----------------------------------------------------------------------------
// rslg_pkg
// Shared types, constants and the LCG step function for the random stream
// generator with gaussian variants.
// ----------------------------------------------------------------------------
`default_nettype none

package rslg_pkg;

    // lcg constants
    localparam logic [11:0] LCG_MULT = 12'd2053;
    localparam logic [15:0] LCG_ADD  = 16'd13849;

    // default index width of the fast gaussian start value
    localparam int GAUSS_INDEX_BITS_DEFAULT = 13;

    // operation codes
    typedef enum logic {
        OP_NEXT   = 1'b0,
        OP_RESEED = 1'b1
    } rslg_op_t;

    // generator mode codes
    localparam logic [1:0] MODE_LCG        = 2'd0;
    localparam logic [1:0] MODE_GAUSS      = 2'd1;
    localparam logic [1:0] MODE_FAST_GAUSS = 2'd2;

    // divide by 12 as (>> 2) then * 43691 >> 17, exact below 2^17
    localparam logic [16:0] DIV3_RECIP = 17'd43691;

    // clamp limits of the signed quotient
    localparam logic signed [17:0] Q_MAX = 18'sd32767;
    localparam logic signed [17:0] Q_MIN = -18'sd32768;

    // bias that turns the signed quotient into 0..65535
    localparam logic [15:0] Q_BIAS = 16'h8000;

    // number of lcg steps in one gaussian value
    localparam logic [3:0] GAUSS_STEPS = 4'd12;

    // input transaction
    typedef struct packed {
        rslg_op_t           operation;
        logic [31:0]        seed;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } rslg_in_t;

    // result transaction
    typedef struct packed {
        logic [31:0]        raw_value;
        logic signed [31:0] ranged_value;
    } rslg_out_t;

    // one 16-bit lcg step: x * 2053 + 13849 mod 2^16
    function automatic logic [15:0] lcg_step(input logic [15:0] x);
        logic [27:0] prod;
        prod = x * LCG_MULT;
        return prod[15:0] + LCG_ADD;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/random_stream_lcg_gaussian_unit.sv =====
// ----------------------------------------------------------------------------
// random_stream_lcg_gaussian_unit
// 16-bit LCG random stream with a twelve-step gaussian and a fast gaussian
// mode, giving a raw value and a value scaled into a signed range.
// ----------------------------------------------------------------------------
// A reseed transaction gives no result. A next transaction in plain LCG
// mode (mode 0 or 3) goes from acceptance to a result in the output register
// through the LCG step, the 16x32 range multiply, and a last step that adds
// the range base and loads the output once the output register is free. In
// the gaussian modes one shared LCG step unit runs twelve times back to back
// (one step per cycle), then the divide by 12 (reciprocal multiply) and the
// clamp follow in their own states before the same range multiply and output
// steps. The input is ready only while the sequencer is idle; a finished
// result waits in the output register and does not hold off the next
// transaction unless a second result is due before the first has been taken.
`default_nettype none

module random_stream_lcg_gaussian_unit #(
    parameter int GAUSS_INDEX_BITS = rslg_pkg::GAUSS_INDEX_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire rslg_pkg::rslg_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output rslg_pkg::rslg_out_t      result,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_data
);
    import rslg_pkg::*;

    // mask of the fast gaussian start value
    localparam logic [15:0] IndexMask = 16'((32'd1 << GAUSS_INDEX_BITS) - 32'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAUSS,
        ST_DIV,
        ST_FIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [15:0]        gen_reg, gen_next;
    logic [15:0]        r_reg, r_next;
    logic signed [19:0] sum_reg, sum_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [33:0]        quo_reg, quo_next;
    logic [15:0]        value_reg, value_next;
    logic [31:0]        lo_reg, lo_next;
    logic [31:0]        span_reg, span_next;
    logic [47:0]        scale_reg, scale_next;
    logic               out_valid_reg, out_valid_next;
    rslg_out_t          out_data_reg, out_data_next;

    logic [15:0]        lcg_in;
    logic [15:0]        lcg_out;
    logic [18:0]        sum_abs;
    logic [33:0]        div_prod;
    logic signed [17:0] q_signed;
    logic [15:0]        q_biased;
    logic [47:0]        scale_prod;
    logic               accept;

    // shared lcg step unit
    assign lcg_in  = (state_reg == ST_GAUSS) ? r_reg : gen_reg;
    assign lcg_out = lcg_step(lcg_in);

    // divide by 12: magnitude / 4, then reciprocal multiply by 1/3
    assign sum_abs  = sum_reg[19] ? 19'(-sum_reg) : 19'(sum_reg);
    assign div_prod = sum_abs[18:2] * DIV3_RECIP;

    // sign, clamp and bias of the quotient
    always_comb
    begin
        q_signed = neg_reg ? -$signed({1'b0, quo_reg[33:17]})
                           : $signed({1'b0, quo_reg[33:17]});
        if (q_signed > Q_MAX)
        begin
            q_signed = Q_MAX;
        end
        else if (q_signed < Q_MIN)
        begin
            q_signed = Q_MIN;
        end
        q_biased = q_signed[15:0] ^ Q_BIAS;
    end

    // range multiply: upper 32 of (value << 16) * span
    assign scale_prod = value_reg * span_reg;

    assign accept       = item_valid && item_ready;
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        gen_next       = gen_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        value_next     = value_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;

        if (wr_en)
        begin
            mode_next = wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lo_next   = item.range_low;
                    span_next = item.range_high - item.range_low + 32'd1;
                    sum_next  = '0;
                    cnt_next  = '0;
                    if (item.operation == OP_RESEED)
                    begin
                        gen_next = item.seed[15:0] ^ item.seed[31:16];
                    end
                    else if (mode_reg == MODE_GAUSS)
                    begin
                        r_next     = gen_reg;
                        state_next = ST_GAUSS;
                    end
                    else if (mode_reg == MODE_FAST_GAUSS)
                    begin
                        gen_next   = lcg_out;
                        r_next     = lcg_out & IndexMask;
                        state_next = ST_GAUSS;
                    end
                    else
                    begin
                        gen_next   = lcg_out;
                        value_next = lcg_out;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_GAUSS:
            begin
                // even steps add, odd steps subtract
                r_next   = lcg_out;
                sum_next = cnt_reg[0] ? sum_reg - $signed({4'b0, lcg_out})
                                      : sum_reg + $signed({4'b0, lcg_out});
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == GAUSS_STEPS - 4'd1)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                neg_next   = sum_reg[19];
                quo_next   = div_prod;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                value_next = q_biased;
                if (mode_reg == MODE_GAUSS)
                begin
                    gen_next = q_biased;
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                scale_next = scale_prod;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for a free output register
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.raw_value    = {value_reg, 16'h0000};
                    out_data_next.ranged_value = lo_reg + scale_reg[47:16];
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LCG;
            gen_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            gen_reg       <= gen_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        value_reg    <= value_next;
        lo_reg       <= lo_next;
        span_reg     <= span_next;
        scale_reg    <= scale_next;
    end

    // step counter never runs past the twelfth lcg step
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAUSS) |-> (cnt_reg < GAUSS_STEPS))
        else $error("gaussian step counter out of range");

    // reseed transaction loads the folded seed
    a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_RESEED)
        |=> (gen_reg == ($past(item.seed[15:0]) ^ $past(item.seed[31:16]))))
        else $error("reseed did not load folded seed");

    // quotient magnitude stays within 16-bit signed range
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (quo_reg[33:17] <= 17'd32767))
        else $error("divide by 12 quotient out of range");

    // a result always has a zero lower half in the raw value
    a_raw_low: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.raw_value[15:0] == 16'h0000))
        else $error("raw value lower half not zero");

    // a finished result is never dropped while waiting in the output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !result_ready) |=> (state_reg == ST_OUT))
        else $error("result overwritten before transaction");

endmodule

`default_nettype wire
